// ===== rtl/stepper_ramp_pulse_generator_macros.svh =====
// Assertion macros used by the stepper ramp pulse generator controller.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRPG_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srpg: same-cycle assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRPG_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srpg: next-cycle assertion failed");

`endif

// ===== rtl/srpg_pkg.sv =====
// Package with the types and constants of the stepper ramp pulse generator.
`default_nettype none

package srpg_pkg;

    // Field widths.
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned STEPS_W    = 17;  // holds a step count of 32768
    localparam int unsigned INDEX_W    = 16;
    localparam int unsigned NUM_W      = INDEX_W + 2;
    localparam int unsigned DIVIDEND_W = INTERVAL_W + NUM_W;
    localparam int unsigned DIV_STEPS  = DIVIDEND_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned CFG_ADDR_W = 1;

    // Commands carried by a request.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_INTERVAL   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_INTERVAL = 1'b1;

    localparam logic [INTERVAL_W-1:0] FIRST_INTERVAL_RESET = 16'd1600;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] move_steps;
    } in_t;

    typedef struct packed {
        logic        step_pulse;
        logic        direction;
        logic [15:0] compare_value;
        logic        done_res;
    } out_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic ramp;
        logic div_start;
        logic apply;
        logic load_result;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic go_ramp;
        logic need_div;
        logic div_busy;
        logic div_done;
        logic out_free;
        logic out_valid;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/srpg_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module srpg_divider (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start_i,
    input  wire logic [srpg_pkg::DIVIDEND_W-1:0]   dividend_i,
    input  wire logic [srpg_pkg::NUM_W-1:0]        divisor_i,
    output logic                                   busy_o,
    output logic                                   done_o,
    output logic [srpg_pkg::DIVIDEND_W-1:0]        quotient_o
);

    localparam int unsigned QW = srpg_pkg::DIVIDEND_W;
    localparam int unsigned DW = srpg_pkg::NUM_W;
    localparam int unsigned CW = srpg_pkg::DIV_CNT_W;

    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i) begin
            quo_next  = dividend_i;
            rem_next  = '0;
            den_next  = divisor_i;
            cnt_next  = CW'(srpg_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy_o     = busy_reg;
    assign done_o     = done_reg;
    assign quotient_o = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/srpg_datapath.sv =====
// Datapath of the stepper ramp pulse generator: move state, ramp arithmetic, result register.
`default_nettype none

module srpg_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire srpg_pkg::ctrl_cmd_t                  cmd_i,
    output srpg_pkg::ctrl_status_t                    status_o,
    input  wire srpg_pkg::in_t                        s_data_i,
    input  wire logic                                 cfg_we_i,
    input  wire logic [srpg_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
    input  wire logic [srpg_pkg::INTERVAL_W-1:0]      cfg_wdata_i,
    input  wire logic                                 m_ready_i,
    output logic                                      m_valid_o,
    output srpg_pkg::out_t                            m_data_o
);

    localparam int unsigned IW = srpg_pkg::INTERVAL_W;
    localparam int unsigned SW = srpg_pkg::STEPS_W;
    localparam int unsigned NW = srpg_pkg::INDEX_W;
    localparam int unsigned MW = srpg_pkg::NUM_W;
    localparam int unsigned QW = srpg_pkg::DIVIDEND_W;

    logic [IW-1:0] min_interval_reg, min_interval_next;
    logic [IW-1:0] first_interval_reg, first_interval_next;
    logic [SW-1:0] steps_done_reg, steps_done_next;
    logic [SW-1:0] steps_total_reg, steps_total_next;
    logic [SW-1:0] ramp_length_reg, ramp_length_next;
    logic [NW-1:0] ramp_index_reg, ramp_index_next;
    logic [IW-1:0] delay_reg, delay_next;
    logic          active_reg, active_next;
    logic          dir_reg, dir_next;
    logic          pulse_reg, pulse_next;
    logic          start_flag_reg, start_flag_next;
    logic          accel_reg, accel_next;
    logic          m_valid_reg, m_valid_next;
    srpg_pkg::out_t m_data_reg, m_data_next;

    logic          is_tick;
    logic [SW-1:0] raw_ext;
    logic [SW-1:0] magnitude;
    logic          accel_cond;
    logic          decel_cond;
    logic [NW-1:0] index_inc;
    logic [NW-1:0] index_dec;
    logic [MW-1:0] num;
    logic [MW-1:0] den_decel;
    logic [QW-1:0] product;
    logic [QW-1:0] div_dividend;
    logic [MW-1:0] div_divisor;
    logic [QW-1:0] quotient;
    logic          div_busy;
    logic          div_done;
    logic [SW-1:0] accel_diff;
    logic [IW-1:0] accel_delay;
    logic [IW-1:0] decel_delay;
    logic [IW:0]   cmp_sum;
    logic [IW-1:0] cmp_value;
    logic          out_free;

    assign is_tick   = (s_data_i.cmd == srpg_pkg::CMD_TICK);
    assign raw_ext   = {1'b0, $unsigned(s_data_i.move_steps)};
    assign magnitude = s_data_i.move_steps[15] ? (SW'(1) << IW) - raw_ext : raw_ext;

    assign accel_cond = (ramp_length_reg == '0);
    assign decel_cond = (steps_done_reg >= (steps_total_reg - ramp_length_reg));
    assign index_inc  = (ramp_index_reg != '1) ? ramp_index_reg + 1'b1 : ramp_index_reg;
    assign index_dec  = (ramp_index_reg > NW'(1)) ? ramp_index_reg - 1'b1 : ramp_index_reg;

    // 4n+1 feeds both ramp directions; deceleration divides by 4n-1.
    assign num          = {ramp_index_reg, 2'b00} + MW'(1);
    assign den_decel    = {ramp_index_reg, 2'b00} - MW'(1);
    assign product      = QW'(delay_reg) * QW'(num);
    assign div_dividend = accel_reg ? {{(QW-IW-1){1'b0}}, delay_reg, 1'b0} : product;
    assign div_divisor  = accel_reg ? num : den_decel;

    srpg_divider u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (cmd_i.div_start),
        .dividend_i (div_dividend),
        .divisor_i  (div_divisor),
        .busy_o     (div_busy),
        .done_o     (div_done),
        .quotient_o (quotient)
    );

    // The acceleration quotient never exceeds 2d/5, so 17 bits hold it.
    assign accel_diff  = {1'b0, delay_reg} - quotient[SW-1:0];
    assign accel_delay = accel_diff[IW-1:0];
    assign decel_delay = (quotient[QW-1:IW] != '0) ? '1 : quotient[IW-1:0];

    assign cmp_sum   = {1'b0, min_interval_reg} + {1'b0, delay_reg};
    assign cmp_value = start_flag_reg ? first_interval_reg
                     : (cmp_sum[IW] ? '1 : cmp_sum[IW-1:0]);

    assign out_free = !m_valid_reg || m_ready_i;

    always_comb begin
        min_interval_next   = min_interval_reg;
        first_interval_next = first_interval_reg;
        steps_done_next     = steps_done_reg;
        steps_total_next    = steps_total_reg;
        ramp_length_next    = ramp_length_reg;
        ramp_index_next     = ramp_index_reg;
        delay_next          = delay_reg;
        active_next         = active_reg;
        dir_next            = dir_reg;
        pulse_next          = pulse_reg;
        start_flag_next     = start_flag_reg;
        accel_next          = accel_reg;
        m_valid_next        = m_valid_reg;
        m_data_next         = m_data_reg;

        if (cfg_we_i) begin
            unique case (cfg_addr_i)
                srpg_pkg::REG_MIN_INTERVAL:   min_interval_next   = cfg_wdata_i;
                srpg_pkg::REG_FIRST_INTERVAL: first_interval_next = cfg_wdata_i;
                default: ;
            endcase
        end

        if (cmd_i.accept) begin
            pulse_next      = 1'b0;
            start_flag_next = !is_tick;
            if (!is_tick) begin
                dir_next         = s_data_i.move_steps[15];
                steps_total_next = magnitude;
                delay_next       = first_interval_reg;
                steps_done_next  = '0;
                ramp_index_next  = '0;
                ramp_length_next = '0;
                active_next      = 1'b1;
            end else if (active_reg) begin
                if (steps_done_reg < steps_total_reg) begin
                    pulse_next      = 1'b1;
                    steps_done_next = steps_done_reg + 1'b1;
                end else begin
                    active_next = 1'b0;
                    delay_next  = min_interval_reg;
                end
            end
        end

        if (cmd_i.ramp) begin
            accel_next = accel_cond;
            if (accel_cond) begin
                ramp_index_next = index_inc;
            end else if (decel_cond) begin
                ramp_index_next = index_dec;
            end
        end

        if (cmd_i.apply) begin
            if (accel_reg) begin
                if (accel_delay <= min_interval_reg) begin
                    delay_next       = min_interval_reg;
                    ramp_length_next = steps_done_reg;
                end else begin
                    delay_next = accel_delay;
                end
                if (steps_done_reg >= (steps_total_reg >> 1)) begin
                    ramp_length_next = steps_done_reg;
                end
            end else begin
                delay_next = decel_delay;
            end
        end

        if (cmd_i.load_result) begin
            m_valid_next              = 1'b1;
            m_data_next.step_pulse    = pulse_reg;
            m_data_next.direction     = dir_reg;
            m_data_next.compare_value = cmp_value;
            m_data_next.done_res      = !active_reg;
        end else if (m_ready_i) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_interval_reg   <= '0;
            first_interval_reg <= srpg_pkg::FIRST_INTERVAL_RESET;
            steps_done_reg     <= '0;
            steps_total_reg    <= '0;
            ramp_length_reg    <= '0;
            ramp_index_reg     <= '0;
            delay_reg          <= '0;
            active_reg         <= 1'b0;
            dir_reg            <= 1'b0;
            pulse_reg          <= 1'b0;
            start_flag_reg     <= 1'b0;
            accel_reg          <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            min_interval_reg   <= min_interval_next;
            first_interval_reg <= first_interval_next;
            steps_done_reg     <= steps_done_next;
            steps_total_reg    <= steps_total_next;
            ramp_length_reg    <= ramp_length_next;
            ramp_index_reg     <= ramp_index_next;
            delay_reg          <= delay_next;
            active_reg         <= active_next;
            dir_reg            <= dir_next;
            pulse_reg          <= pulse_next;
            start_flag_reg     <= start_flag_next;
            accel_reg          <= accel_next;
            m_valid_reg        <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign status_o.go_ramp   = is_tick && active_reg;
    assign status_o.need_div  = accel_cond || decel_cond;
    assign status_o.div_busy  = div_busy;
    assign status_o.div_done  = div_done;
    assign status_o.out_free  = out_free;
    assign status_o.out_valid = m_valid_reg;

    assign m_valid_o = m_valid_reg;
    assign m_data_o  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/srpg_controller.sv =====
// Controller state machine that sequences one request through the datapath.
`default_nettype none
`include "stepper_ramp_pulse_generator_macros.svh"

module srpg_controller (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire srpg_pkg::ctrl_status_t status_i,
    output srpg_pkg::ctrl_cmd_t         cmd_o
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RAMP   = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_APPLY  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = 1'b1;
                cmd_o.accept = s_valid;
                if (s_valid) begin
                    state_next = status_i.go_ramp ? ST_RAMP : ST_RESULT;
                end
            end
            ST_RAMP: begin
                cmd_o.ramp = 1'b1;
                state_next = status_i.need_div ? ST_MUL : ST_RESULT;
            end
            ST_MUL: begin
                cmd_o.div_start = 1'b1;
                state_next      = ST_DIV;
            end
            ST_DIV: begin
                if (status_i.div_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd_o.apply = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT: begin
                if (status_i.out_free) begin
                    cmd_o.load_result = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SRPG_ASSERT_NXT(a_accept_blocks, aclk, aresetn, cmd_o.accept, !s_ready)
    `SRPG_ASSERT_NXT(a_div_runs, aclk, aresetn, cmd_o.div_start, status_i.div_busy)
    `SRPG_ASSERT_NXT(a_result_shown, aclk, aresetn, cmd_o.load_result, status_i.out_valid)

endmodule

`default_nettype wire

// ===== rtl/stepper_ramp_pulse_generator.sv =====
// Top level of the stepper ramp pulse generator.
// Usage: a request on the s_ channel is either a start (cmd 0, signed step count in
// move_steps) or a timer compare tick (cmd 1). Every request yields exactly one result
// on the m_ channel carrying the step pulse flag, direction level, next compare value
// and the done flag. Requests are taken one at a time: s_ready is high only while the
// sequencer is idle. A start, or a tick while no move is active, goes from acceptance
// straight to the result state. A tick during cruise passes the ramp state first, and a
// tick on a ramp also passes the multiply, divide and apply states, the one-bit-per-cycle
// divider forming d - 2d/(4n+1) or d(4n+1)/(4n-1) after a single 16x18 multiply.
// The result sits in an output register; the next request is accepted while it waits.
// If the receiver stalls, a finished result holds in the sequencer until the output
// register frees, and no request is lost. min_interval (index 0) and first_interval
// (index 1) are written through cfg_we/cfg_addr/cfg_wdata; the user must do so only while
// the block is idle, which the block does not enforce. Synchronous active-low reset clears
// the move state, selects idle, drops m_valid and loads the registers with 0 and 1600.
`default_nettype none

module stepper_ramp_pulse_generator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire srpg_pkg::in_t                    s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output srpg_pkg::out_t                        m_data,
    input  wire logic                             cfg_we,
    input  wire logic [srpg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [srpg_pkg::INTERVAL_W-1:0]  cfg_wdata
);

    // Command and status groups between the sequencer and the datapath.
    srpg_pkg::ctrl_cmd_t    ctrl_cmd;
    srpg_pkg::ctrl_status_t ctrl_status;

    // The controller owns request acceptance and the order of the datapath steps.
    srpg_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .status_i (ctrl_status),
        .cmd_o    (ctrl_cmd)
    );

    // The datapath holds the move state, the configuration and the result register.
    srpg_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_i       (ctrl_cmd),
        .status_o    (ctrl_status),
        .s_data_i    (s_data),
        .cfg_we_i    (cfg_we),
        .cfg_addr_i  (cfg_addr),
        .cfg_wdata_i (cfg_wdata),
        .m_ready_i   (m_ready),
        .m_valid_o   (m_valid),
        .m_data_o    (m_data)
    );

endmodule

`default_nettype wire
